### rtl/core/dtq_pkg.sv
// dtq_pkg: shared types and constants of the deadline timer queue.
// No dependencies.
`default_nettype none

package dtq_pkg;

   localparam int unsigned DELAY_W  = 31;
   localparam int unsigned TAG_W    = 16;
   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned NOW_W    = 32;
   localparam int unsigned MAX_OUT  = 32;
   localparam int unsigned COUNT_W  = 6;
   localparam logic [DELAY_W-1:0] REMAIN_MAX = {DELAY_W{1'b1}};

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_EXPIRE = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ADDED     = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_TIME_LEFT = 3'd2,
      KIND_EXPIRED   = 3'd3,
      KIND_NONE_DUE  = 3'd4
   } kind_type;

endpackage

`default_nettype wire

### rtl/core/dtq_ram.sv
// dtq_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none

module dtq_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

### rtl/core/deadline_timer_queue.sv
// deadline_timer_queue: timer table with add, query and expire commands.
// Depends on dtq_pkg and dtq_ram.
//
//   channel  dir  handshake               contents
//   req      in   req_tvalid/req_tready   tuser command, tdata now/delay/tag
//   rsp      out  rsp_tvalid/rsp_tready   tuser kind, tdata slot/tag/remaining/inf
//
// Every command walks the table one slot per cycle through one RAM read port and one
// subtract-compare. Add stops at the first free slot. Query walks the table once.
// Expire walks it once for each removed entry and once more.
// req_tready is high only while idle; a held response stalls the walk at a decision.
// Reset empties the table at once through per-slot valid bits.
`default_nettype none

module deadline_timer_queue
   import dtq_pkg::*;
#(
   parameter int unsigned TIMER_SLOTS = 32,
   parameter int unsigned TIME_BITS   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // now[31:0], delay[62:32], tag[78:63], zero
   input  wire logic [1:0]  req_tuser,   // command[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // slot[4:0], fired_tag[20:5], remaining[51:21],
                                         // infinite[52], zero
   output logic [2:0]       rsp_tuser,   // kind[2:0]
   output logic             rsp_tlast
);

   localparam int unsigned IDX_W = $clog2(TIMER_SLOTS);
   localparam int unsigned EXT_W = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
   localparam int unsigned RAM_W = TIME_BITS + TAG_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);
   localparam logic [TIME_BITS-1:0] SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_LASTCMP,
      S_DECIDE
   } state_type;

   state_type              state_ff;
   cmd_type                cmd_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [TIME_BITS-1:0]   deadline_ff;
   logic [TAG_W-1:0]       tag_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic                   cmp_act_ff;
   logic [IDX_W-1:0]       cmp_idx_ff;
   logic                   best_found_ff;
   logic [TIME_BITS-1:0]   best_key_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [TAG_W-1:0]       best_tag_ff;
   logic                   pend_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic [TAG_W-1:0]       pend_tag_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic [TIMER_SLOTS-1:0] valid_ff;
   logic                   rsp_valid_ff;
   kind_type               o_kind_ff;
   logic [SLOT_W-1:0]      o_slot_ff;
   logic [TAG_W-1:0]       o_tag_ff;
   logic [DELAY_W-1:0]     o_rem_ff;
   logic                   o_inf_ff;
   logic                   o_last_ff;

   logic [EXT_W-1:0]     now_ext;
   logic [EXT_W-1:0]     sum_ext;
   logic [RAM_W-1:0]     rd_data;
   logic [TIME_BITS-1:0] key_c;
   logic                 take_c;
   logic [TIME_BITS-1:0] best_diff;
   logic [EXT_W-1:0]     diff_ext;
   logic                 due_c;
   logic [DELAY_W-1:0]   rem_c;
   logic                 more_c;
   logic                 out_free;
   logic                 ram_we;

   assign now_ext = EXT_W'(req_tdata[31:0]);
   assign sum_ext = now_ext + EXT_W'(req_tdata[62:32]);

   assign key_c  = (rd_data[TIME_BITS-1:0] - now_ff) ^ SIGN;
   assign take_c = cmp_act_ff && valid_ff[cmp_idx_ff]
                   && (!best_found_ff || (key_c < best_key_ff));

   assign best_diff = best_key_ff ^ SIGN;
   assign diff_ext  = EXT_W'(best_diff);
   assign due_c     = best_found_ff && ((best_diff == '0) || best_diff[TIME_BITS-1]);
   assign more_c    = due_c && (count_ff < COUNT_W'(MAX_OUT));

   always_comb begin
      if (!best_found_ff || (best_diff == '0) || best_diff[TIME_BITS-1]) begin
         rem_c = '0;
      end else if (diff_ext > EXT_W'(REMAIN_MAX)) begin
         rem_c = REMAIN_MAX;
      end else begin
         rem_c = diff_ext[DELAY_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ram_we   = (state_ff == S_ADD) && !valid_ff[addr_ff] && out_free;

   dtq_ram #(
      .WIDTH (RAM_W),
      .DEPTH (TIMER_SLOTS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata ({tag_ff, deadline_ff}),
      .raddr (addr_ff),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      cmp_act_ff <= (state_ff == S_SCAN);
      cmp_idx_ff <= addr_ff;
      if (take_c) begin
         best_found_ff <= 1'b1;
         best_key_ff   <= key_c;
         best_idx_ff   <= cmp_idx_ff;
         best_tag_ff   <= rd_data[RAM_W-1:TIME_BITS];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_ff        <= cmd_type'(req_tuser);
               now_ff        <= now_ext[TIME_BITS-1:0];
               deadline_ff   <= sum_ext[TIME_BITS-1:0];
               tag_ff        <= req_tdata[78:63];
               addr_ff       <= '0;
               best_found_ff <= 1'b0;
               pend_ff       <= 1'b0;
               count_ff      <= '0;
               case (cmd_type'(req_tuser))
                  CMD_ADD:    state_ff <= S_ADD;
                  CMD_QUERY:  state_ff <= S_SCAN;
                  CMD_EXPIRE: state_ff <= S_SCAN;
                  default:    state_ff <= S_IDLE;
               endcase
            end
         end
         S_ADD: begin
            if (!valid_ff[addr_ff]) begin
               if (out_free) begin
                  valid_ff[addr_ff] <= 1'b1;
                  rsp_valid_ff      <= 1'b1;
                  o_kind_ff         <= KIND_ADDED;
                  o_slot_ff         <= SLOT_W'(addr_ff);
                  o_tag_ff          <= tag_ff;
                  o_rem_ff          <= '0;
                  o_inf_ff          <= 1'b0;
                  o_last_ff         <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end else if (addr_ff == LAST_IDX) begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  o_kind_ff    <= KIND_FULL;
                  o_slot_ff    <= '0;
                  o_tag_ff     <= '0;
                  o_rem_ff     <= '0;
                  o_inf_ff     <= 1'b0;
                  o_last_ff    <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end else begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_ff <= S_LASTCMP;
            end else begin
               addr_ff <= addr_ff + 1'b1;
            end
         end
         S_LASTCMP: begin
            state_ff <= S_DECIDE;
         end
         S_DECIDE: begin
            if (cmd_ff == CMD_QUERY) begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  o_kind_ff    <= KIND_TIME_LEFT;
                  o_slot_ff    <= '0;
                  o_tag_ff     <= '0;
                  o_rem_ff     <= rem_c;
                  o_inf_ff     <= !best_found_ff;
                  o_last_ff    <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end else if (more_c && (!pend_ff || out_free)) begin
               // hold the new earliest entry; the previous one goes out, not last
               if (pend_ff) begin
                  rsp_valid_ff <= 1'b1;
                  o_kind_ff    <= KIND_EXPIRED;
                  o_slot_ff    <= SLOT_W'(pend_idx_ff);
                  o_tag_ff     <= pend_tag_ff;
                  o_rem_ff     <= '0;
                  o_inf_ff     <= 1'b0;
                  o_last_ff    <= 1'b0;
               end
               pend_ff               <= 1'b1;
               pend_idx_ff           <= best_idx_ff;
               pend_tag_ff           <= best_tag_ff;
               valid_ff[best_idx_ff] <= 1'b0;
               count_ff              <= count_ff + 1'b1;
               best_found_ff         <= 1'b0;
               addr_ff               <= '0;
               state_ff              <= S_SCAN;
            end else if (!more_c && out_free) begin
               rsp_valid_ff <= 1'b1;
               o_kind_ff    <= pend_ff ? KIND_EXPIRED : KIND_NONE_DUE;
               o_slot_ff    <= pend_ff ? SLOT_W'(pend_idx_ff) : '0;
               o_tag_ff     <= pend_ff ? pend_tag_ff : '0;
               o_rem_ff     <= '0;
               o_inf_ff     <= 1'b0;
               o_last_ff    <= 1'b1;
               state_ff     <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase

      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         cmp_act_ff    <= 1'b0;
         best_found_ff <= 1'b0;
         pend_ff       <= 1'b0;
         count_ff      <= '0;
         addr_ff       <= '0;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {3'b000, o_inf_ff, o_rem_ff, o_tag_ff, o_slot_ff};

endmodule

`default_nettype wire
